FILE: design/tbbeq_pkg.sv
package tbbeq_pkg;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_BAND = 6'b000010,
		ST_FB1  = 6'b000100,
		ST_FB2  = 6'b001000,
		ST_GAIN = 6'b010000,
		ST_SUM  = 6'b100000
	} state_t;

	// Band indexes.
	typedef logic [1:0] band_t;
	localparam band_t BAND_LOW  = 2'd0;
	localparam band_t BAND_MID  = 2'd1;
	localparam band_t BAND_HIGH = 2'd2;
	localparam int    NUM_BANDS = 3;

	// Register indexes on the configuration port.
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_FEEDBACK_FIRST  = 3'd0;
	localparam reg_idx_t REG_FEEDBACK_SECOND = 3'd1;
	localparam reg_idx_t REG_GAIN_LOW        = 3'd2;
	localparam reg_idx_t REG_GAIN_MID        = 3'd3;
	localparam reg_idx_t REG_GAIN_HIGH       = 3'd4;

	// Reset values of the configuration registers.
	localparam logic signed [17:0] FEEDBACK_FIRST_RST  = -18'sd62019;
	localparam logic signed [16:0] FEEDBACK_SECOND_RST = 17'sd20225;
	localparam logic [17:0]        GAIN_LOW_RST        = 18'd46396;
	localparam logic [17:0]        GAIN_MID_RST        = 18'd65536;
	localparam logic [17:0]        GAIN_HIGH_RST       = 18'd52057;

	localparam int ACC_W = 48;
	localparam int EXT_W = 50;

	// Saturate a 50-bit sum to the 48-bit accumulator range.
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [EXT_W-1:0] v);
		logic ovf;
		ovf = (v[EXT_W-1:ACC_W-1] != '0) && (v[EXT_W-1:ACC_W-1] != '1);
		if (!ovf) begin
			sat_acc = v[ACC_W-1:0];
		end else if (v[EXT_W-1]) begin
			sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

	// Saturate a 48-bit value to 16 bits.
	function automatic logic signed [15:0] sat16_acc(input logic signed [ACC_W-1:0] v);
		logic ovf;
		ovf = (v[ACC_W-1:15] != '0) && (v[ACC_W-1:15] != '1);
		if (!ovf) begin
			sat16_acc = v[15:0];
		end else if (v[ACC_W-1]) begin
			sat16_acc = 16'sh8000;
		end else begin
			sat16_acc = 16'sh7fff;
		end
	endfunction

	// Saturate the 18-bit band sum to 16 bits.
	function automatic logic signed [15:0] sat16_sum(input logic signed [17:0] v);
		logic ovf;
		ovf = (v[17:15] != 3'b000) && (v[17:15] != 3'b111);
		if (!ovf) begin
			sat16_sum = v[15:0];
		end else if (v[17]) begin
			sat16_sum = 16'sh8000;
		end else begin
			sat16_sum = 16'sh7fff;
		end
	endfunction

endpackage

FILE: design/three_band_biquad_equalizer_top.sv
// Three-band biquad equalizer. Each request carries one signed 16-bit sample, which runs
// through a low-pass, a band-pass and a high-pass transposed direct form II biquad; each
// band output is saturated, scaled by its gain register, saturated again, and the three
// bands are summed and clamped into one 16-bit result. The work is done by one shared
// 19x16-bit signed multiplier under a small sequencer: every band needs three products
// (a1*s, a2*s and gain*s) and steps through the states BAND, FB1, FB2, GAIN and SUM, so
// a new request is not accepted until the sequencer has finished the previous one and
// returned to IDLE. in_stall stays high for the whole computation. The result sits in an
// output register, so a stalled output does not block a new request; only when a result
// is finished while the previous one is still waiting does the sequencer hold. The five
// coefficient and gain registers are written over the APB port at byte addresses 0, 4, 8,
// 12 and 16 and should only be changed while no request is in flight. FRAC_BITS sets the
// fixed-point position of the coefficients, gains and delay states.
module three_band_biquad_equalizer_top
	import tbbeq_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// Sample request channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] in_sample,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_sample,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Configuration registers.
	logic signed [17:0] feedback_first_q;
	logic signed [16:0] feedback_second_q;
	logic [17:0]        gain_low_q;
	logic [17:0]        gain_mid_q;
	logic [17:0]        gain_high_q;

	// Sequencer and datapath registers.
	state_t                    state_q;
	band_t                     band_q;
	logic signed [15:0]        x_q;
	logic signed [15:0]        s_q;
	logic signed [34:0]        prod_q;
	logic signed [17:0]        sum_q;
	logic signed [ACC_W-1:0]   delay_first_q [NUM_BANDS];
	logic signed [ACC_W-1:0]   delay_second_q [NUM_BANDS];
	logic                      out_valid_q;
	logic signed [15:0]        out_sample_q;

	reg_idx_t                  reg_idx;
	logic                      cfg_write;

	logic signed [EXT_W-1:0]   x_ext;
	logic signed [EXT_W-1:0]   x_quarter;
	logic signed [EXT_W-1:0]   x_half;
	logic signed [EXT_W-1:0]   num1_term;
	logic signed [EXT_W-1:0]   num2_term;
	logic signed [EXT_W-1:0]   prod_ext;
	logic signed [EXT_W-1:0]   acc_sum;
	logic signed [EXT_W-1:0]   d1_sum;
	logic signed [EXT_W-1:0]   d2_sum;
	logic signed [ACC_W-1:0]   acc_sat;
	logic signed [ACC_W-1:0]   acc_shr;
	logic signed [15:0]        s_next;
	logic signed [ACC_W-1:0]   gain_shr;
	logic signed [15:0]        band_gained;
	logic signed [17:0]        sum_next;
	logic signed [18:0]        mul_a;
	logic signed [34:0]        mul_res;
	logic                      last_band;
	logic                      finish;

	// The APB port never waits; a write lands on the access cycle.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_FEEDBACK_FIRST:  prdata = {{14{feedback_first_q[17]}}, feedback_first_q};
			REG_FEEDBACK_SECOND: prdata = {{15{feedback_second_q[16]}}, feedback_second_q};
			REG_GAIN_LOW:        prdata = {14'd0, gain_low_q};
			REG_GAIN_MID:        prdata = {14'd0, gain_mid_q};
			REG_GAIN_HIGH:       prdata = {14'd0, gain_high_q};
			default:             prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_first_q  <= FEEDBACK_FIRST_RST;
			feedback_second_q <= FEEDBACK_SECOND_RST;
			gain_low_q        <= GAIN_LOW_RST;
			gain_mid_q        <= GAIN_MID_RST;
			gain_high_q       <= GAIN_HIGH_RST;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_FEEDBACK_FIRST:  feedback_first_q  <= pwdata[17:0];
				REG_FEEDBACK_SECOND: feedback_second_q <= pwdata[16:0];
				REG_GAIN_LOW:        gain_low_q        <= pwdata[17:0];
				REG_GAIN_MID:        gain_mid_q        <= pwdata[17:0];
				REG_GAIN_HIGH:       gain_high_q       <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	// The numerator taps are powers of two, so they are shifts of the sample.
	assign x_ext     = {{(EXT_W-16){x_q[15]}}, x_q};
	assign x_quarter = x_ext <<< (FRAC_BITS - 2);
	assign x_half    = x_ext <<< (FRAC_BITS - 1);

	always_comb begin
		case (band_q)
			BAND_LOW: begin
				num1_term = x_half;
				num2_term = x_quarter;
			end
			BAND_MID: begin
				num1_term = '0;
				num2_term = -x_quarter;
			end
			BAND_HIGH: begin
				num1_term = -x_half;
				num2_term = x_quarter;
			end
			default: begin
				num1_term = '0;
				num2_term = '0;
			end
		endcase
	end

	// The shared multiplier: a1, a2 or the band gain times the band output.
	always_comb begin
		case (state_q)
			ST_FB1:  mul_a = {feedback_first_q[17], feedback_first_q};
			ST_FB2:  mul_a = {{2{feedback_second_q[16]}}, feedback_second_q};
			ST_GAIN: begin
				case (band_q)
					BAND_LOW:  mul_a = {1'b0, gain_low_q};
					BAND_MID:  mul_a = {1'b0, gain_mid_q};
					BAND_HIGH: mul_a = {1'b0, gain_high_q};
					default:   mul_a = '0;
				endcase
			end
			default: mul_a = '0;
		endcase
	end
	assign mul_res = mul_a * s_q;

	assign prod_ext = {{(EXT_W-35){prod_q[34]}}, prod_q};

	// Band output from the first delay state.
	assign acc_sum = x_quarter + {{(EXT_W-ACC_W){delay_first_q[band_q][ACC_W-1]}},
		delay_first_q[band_q]};
	assign acc_sat = sat_acc(acc_sum);
	assign acc_shr = acc_sat >>> FRAC_BITS;
	assign s_next  = sat16_acc(acc_shr);

	// Delay state updates, each using the product registered the cycle before.
	assign d1_sum = num1_term - prod_ext + {{(EXT_W-ACC_W){delay_second_q[band_q][ACC_W-1]}},
		delay_second_q[band_q]};
	assign d2_sum = num2_term - prod_ext;

	// Gained band and running sum. The gained product is shifted as a signed value so
	// that negative bands round toward minus infinity.
	assign gain_shr    = $signed(prod_ext[ACC_W-1:0]) >>> FRAC_BITS;
	assign band_gained = sat16_acc(gain_shr);
	assign sum_next    = sum_q + {{2{band_gained[15]}}, band_gained};

	assign last_band = (band_q == BAND_HIGH);
	// The last band may only retire when the output register is free or being emptied.
	assign finish    = (state_q == ST_SUM) && last_band && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			band_q      <= BAND_LOW;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_BANDS; k++) begin
				delay_first_q[k]  <= '0;
				delay_second_q[k] <= '0;
			end
		end else begin
			// A finished result refills the output register in the same cycle that the
			// previous one is taken.
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						band_q  <= BAND_LOW;
						state_q <= ST_BAND;
					end
				end
				ST_BAND: begin
					state_q <= ST_FB1;
				end
				ST_FB1: begin
					state_q <= ST_FB2;
				end
				ST_FB2: begin
					delay_first_q[band_q] <= sat_acc(d1_sum);
					state_q               <= ST_GAIN;
				end
				ST_GAIN: begin
					delay_second_q[band_q] <= sat_acc(d2_sum);
					state_q                <= ST_SUM;
				end
				ST_SUM: begin
					if (!last_band) begin
						band_q  <= band_q + 2'd1;
						state_q <= ST_BAND;
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x_q   <= in_sample;
					sum_q <= '0;
				end
			end
			ST_BAND: s_q    <= s_next;
			ST_FB1:  prod_q <= mul_res;
			ST_FB2:  prod_q <= mul_res;
			ST_GAIN: prod_q <= mul_res;
			ST_SUM: begin
				if (!last_band) begin
					sum_q <= sum_next;
				end else if (finish) begin
					out_sample_q <= sat16_sum(sum_next);
				end
			end
			default: ;
		endcase
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

endmodule
